### rtl/nzce_pkg.sv
// Shared constants and types of the nonzero coordinate extractor.
package nzce_pkg;

  // Field widths
  localparam int unsigned ElemW    = 64;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DimW     = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Number of extent registers and default dimension limit
  localparam int unsigned SizeRegs       = 6;
  localparam int unsigned MaxDimsDefault = 6;

  // Depth of the run queue between front and back
  localparam int unsigned QueueDepth = 4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegElementKind = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDimsInUse   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegSizeDim0    = 8'd2;

  // Element kinds
  localparam logic [KindW-1:0] KindInteger = 2'd0;
  localparam logic [KindW-1:0] KindFloat32 = 2'd1;
  localparam logic [KindW-1:0] KindFloat64 = 2'd2;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/nonzero_coordinate_extractor.sv
// Top level of the nonzero coordinate extractor.
// Accepts one tensor element per cycle in row-major order while the four-run
// queue has room, and for each nonzero element sends one coordinate per
// dimension in use (dimension 0 first, tlast on the final one, tuser giving
// the dimension). The output stage sends one coordinate per cycle while the
// sink is ready, so the sustained rate is one element per cycle as long as
// nonzero elements times dimensions in use average at most one per cycle;
// zero elements never occupy the queue. cfg_ready_o is always high; every
// write to an index below 8 restarts the coordinate counter at the origin;
// writes must be made only while idle, which the block does not enforce.
module nonzero_coordinate_extractor #(
  parameter int unsigned MAX_DIMENSIONS = nzce_pkg::MaxDimsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // element_value
  input  logic [nzce_pkg::ElemW-1:0]      s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // coordinate
  output logic [nzce_pkg::CoordW-1:0]     m_axis_tdata_o,
  // dimension
  output logic [nzce_pkg::DimW-1:0]       m_axis_tuser_o,
  output logic                            m_axis_tlast_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nzce_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [nzce_pkg::CfgDataW-1:0]   cfg_data_i
);
  import nzce_pkg::*;

  localparam int unsigned NumDims =
    (MAX_DIMENSIONS < SizeRegs) ? MAX_DIMENSIONS : SizeRegs;
  localparam int unsigned EntryW  = NumDims * CoordW + DimW;

  q_status_t                  q_status;
  logic                       push;
  logic                       pop;
  logic [NumDims*CoordW-1:0]  push_digits;
  logic [DimW-1:0]            push_dims;
  logic [EntryW-1:0]          head_data;

  nzce_front #(
    .DIM_SLOTS (NumDims)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_digits_o   (push_digits),
    .push_dims_o     (push_dims)
  );

  nzce_fifo #(
    .DEPTH  (QueueDepth),
    .DATA_W (EntryW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_dims, push_digits}),
    .pop_i       (pop),
    .head_data_o (head_data),
    .status_o    (q_status)
  );

  nzce_back #(
    .DIM_SLOTS (NumDims)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_digits_i   (head_data[NumDims*CoordW-1:0]),
    .head_dims_i     (head_data[EntryW-1 -: DimW]),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

endmodule

### rtl/nzce_front.sv
// Front end: configuration registers, nonzero test and coordinate counter.
module nzce_front #(
  parameter int unsigned DIM_SLOTS = nzce_pkg::SizeRegs
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [nzce_pkg::ElemW-1:0]                 s_axis_tdata_i,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [nzce_pkg::CfgIdxW-1:0]               cfg_index_i,
  input  logic [nzce_pkg::CfgDataW-1:0]              cfg_data_i,
  input  nzce_pkg::q_status_t                        q_status_i,
  output logic                                       push_o,
  output logic [DIM_SLOTS*nzce_pkg::CoordW-1:0]      push_digits_o,
  output logic [nzce_pkg::DimW-1:0]                  push_dims_o
);
  import nzce_pkg::*;

  logic [KindW-1:0]  kind_q;
  logic [DimW-1:0]   dims_q;
  logic [CoordW-1:0] size_q  [DIM_SLOTS];
  logic [CoordW-1:0] digit_q [DIM_SLOTS];
  logic [CoordW-1:0] digit_d [DIM_SLOTS];
  logic [DimW-1:0]   n_act;
  logic              nonzero;
  logic              accept;
  logic              cfg_hit;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_status_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_hit         = cfg_valid_i &&
                           (cfg_index_i < (RegSizeDim0 + CfgIdxW'(SizeRegs)));

  // Clamp the dimension count to the supported range
  always_comb begin
    if (dims_q == '0) begin
      n_act = DimW'(1);
    end else if (dims_q > DimW'(DIM_SLOTS)) begin
      n_act = DimW'(DIM_SLOTS);
    end else begin
      n_act = dims_q;
    end
  end

  // Zero test by element kind; floats ignore the sign bit
  always_comb begin
    case (kind_q)
      KindFloat32: nonzero = |s_axis_tdata_i[30:0];
      KindFloat64: nonzero = |s_axis_tdata_i[62:0];
      default:     nonzero = |s_axis_tdata_i;
    endcase
  end

  // Mixed-radix increment: each digit wraps at its own extent, carry is an AND chain
  always_comb begin
    logic              carry;
    logic [CoordW:0]   nxt;
    logic [CoordW-1:0] ext;
    logic              wrap;
    carry = 1'b1;
    for (int d = 0; d < DIM_SLOTS; d++) begin
      digit_d[d] = digit_q[d];
    end
    for (int d = DIM_SLOTS - 1; d >= 0; d--) begin
      ext  = (size_q[d] == '0) ? CoordW'(1) : size_q[d];
      nxt  = {1'b0, digit_q[d]} + (CoordW + 1)'(1);
      wrap = nxt >= {1'b0, ext};
      if ((DimW'(d) < n_act) && carry) begin
        digit_d[d] = wrap ? '0 : nxt[CoordW-1:0];
        carry      = wrap;
      end
    end
  end

  // Hand the current coordinate to the queue for nonzero elements
  always_comb begin
    for (int d = 0; d < DIM_SLOTS; d++) begin
      push_digits_o[d*CoordW +: CoordW] = digit_q[d];
    end
  end
  assign push_o      = accept && nonzero;
  assign push_dims_o = n_act;

  // Register writes (index below 8) clear the counter; otherwise accepted elements advance it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindInteger;
      dims_q <= DimW'(1);
      for (int d = 0; d < DIM_SLOTS; d++) begin
        size_q[d]  <= CoordW'(1);
        digit_q[d] <= '0;
      end
    end else if (cfg_hit) begin
      if (cfg_index_i == RegElementKind) begin
        kind_q <= cfg_data_i[KindW-1:0];
      end
      if (cfg_index_i == RegDimsInUse) begin
        dims_q <= cfg_data_i[DimW-1:0];
      end
      for (int d = 0; d < DIM_SLOTS; d++) begin
        if (cfg_index_i == (RegSizeDim0 + CfgIdxW'(d))) begin
          size_q[d] <= cfg_data_i[CoordW-1:0];
        end
        digit_q[d] <= '0;
      end
    end else if (accept) begin
      for (int d = 0; d < DIM_SLOTS; d++) begin
        digit_q[d] <= digit_d[d];
      end
    end
  end

endmodule

### rtl/nzce_fifo.sv
// Short queue of coordinate runs between the front and the back.
module nzce_fifo #(
  parameter int unsigned DEPTH  = nzce_pkg::QueueDepth,
  parameter int unsigned DATA_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [DATA_W-1:0]   push_data_i,
  input  logic                pop_i,
  output logic [DATA_W-1:0]   head_data_o,
  output nzce_pkg::q_status_t status_o
);
  import nzce_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_data_o    = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### rtl/nzce_back.sv
// Back end: serializes one queued run into coordinate transfers.
module nzce_back #(
  parameter int unsigned DIM_SLOTS = nzce_pkg::SizeRegs
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [DIM_SLOTS*nzce_pkg::CoordW-1:0] head_digits_i,
  input  logic [nzce_pkg::DimW-1:0]             head_dims_i,
  input  nzce_pkg::q_status_t                   q_status_i,
  output logic                                  pop_o,
  output logic [nzce_pkg::CoordW-1:0]           m_axis_tdata_o,
  output logic [nzce_pkg::DimW-1:0]             m_axis_tuser_o,
  output logic                                  m_axis_tlast_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i
);
  import nzce_pkg::*;

  localparam int unsigned IdxW = (DIM_SLOTS > 1) ? $clog2(DIM_SLOTS) : 1;

  logic [IdxW-1:0]   idx_q;
  logic              valid_q;
  logic [CoordW-1:0] coord_q;
  logic [DimW-1:0]   dim_q;
  logic              last_q;
  logic              load;
  logic              is_last;

  assign load    = !q_status_i.empty && (!valid_q || m_axis_tready_i);
  assign is_last = (DimW'(idx_q) + DimW'(1)) == head_dims_i;
  assign pop_o   = load && is_last;

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = coord_q;
  assign m_axis_tuser_o  = dim_q;
  assign m_axis_tlast_o  = last_q;

  // Walk the dimensions of the head run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= is_last ? '0 : idx_q + IdxW'(1);
        valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      coord_q <= head_digits_i[idx_q*CoordW +: CoordW];
      dim_q   <= DimW'(idx_q);
      last_q  <= is_last;
    end
  end

endmodule

### rtl/nzce_checker.sv
// Port-level checks of the nonzero coordinate extractor, bound to the top level.
module nzce_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic [nzce_pkg::CoordW-1:0]   m_axis_tdata_o,
  input logic [nzce_pkg::DimW-1:0]     m_axis_tuser_o,
  input logic                          m_axis_tlast_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i
);
  import nzce_pkg::*;

  // Hold a stalled coordinate transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // A run continues without a gap on the next dimension
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o) + DimW'(1)))
    else $error("run broken or dimension out of sequence");

  // A run never starts past the first dimension: after a last, dimension 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=>
      !m_axis_tvalid_o || (m_axis_tuser_o == '0))
    else $error("run did not start at dimension 0");

endmodule

bind nonzero_coordinate_extractor nzce_checker u_nzce_checker (.*);
